FILE: rtl/core/skf_pkg.sv
// Shared constants and types for the per-channel scalar Kalman filter.
// Used by skf_divider and scalar_kalman_filter_channels_core; no dependencies.
package skf_pkg;

  // Number of sensor channels that keep their own filter state
  localparam int CHANNELS = 4;

  // Field widths
  localparam int CH_W    = 2;   // channel number
  localparam int MEAS_W  = 16;  // signed integer measurement
  localparam int VAR_W   = 24;  // unsigned Q8.16 variance
  localparam int EST_W   = 24;  // signed Q16.8 estimate
  localparam int GAIN_W  = 16;  // unsigned Q0.16 gain
  localparam int DEN_W   = VAR_W + 1;
  localparam int DIV_CNT_W = $clog2(GAIN_W + 1);

  // Datapath widths of the shared multiplier and the estimate update
  localparam int PROD_W = 44;
  localparam int DIFF_W = EST_W + 1;
  localparam int SUM_W  = PROD_W - GAIN_W;

  // Reset values of the registers and the channel state
  localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = 24'd655;
  localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 24'd65536;
  localparam logic [VAR_W-1:0] VARIANCE_RST          = 24'd65536;

  // Limits
  localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  // Configuration register indexes
  localparam logic REG_PROCESS_NOISE     = 1'b0;
  localparam logic REG_MEASUREMENT_NOISE = 1'b1;

  // Item commands
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_FORCE  = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [VAR_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/core/skf_divider.sv
// Iterative restoring divider: quot = floor(num * 2^16 / den), one bit a cycle.
// Requires num < den. Depends on skf_pkg.
module skf_divider (
  input  logic              clk,
  input  logic              rst,
  input  skf_pkg::div_req_t req,
  output skf_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic [skf_pkg::DIV_CNT_W-1:0]   count;
  logic [skf_pkg::DEN_W:0]         rem;
  logic [skf_pkg::DEN_W-1:0]       den;
  logic [skf_pkg::GAIN_W-1:0]      quot;
  logic                            done;

  logic [skf_pkg::DEN_W:0]         rem_sh;
  logic [skf_pkg::DEN_W:0]         rem_sub;
  logic                            fits;

  // One shift, compare and subtract per cycle
  always_comb begin
    rem_sh  = {rem[skf_pkg::DEN_W-1:0], 1'b0};
    fits    = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  // Sequence the sixteen quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= {2'b00, req.num};
        den   <= req.den;
        quot  <= '0;
      end else if (busy) begin
        rem   <= fits ? rem_sub : rem_sh;
        quot  <= {quot[skf_pkg::GAIN_W-2:0], fits};
        count <= count + skf_pkg::DIV_CNT_W'(1);
        if (count == skf_pkg::DIV_CNT_W'(skf_pkg::GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

FILE: rtl/core/scalar_kalman_filter_channels_core.sv
// Per-channel scalar Kalman filter: sequencer, channel state, shared multiplier.
// Depends on skf_pkg and skf_divider.
//
//   channel   handshake            payload
//   item      item_valid/stall     command, channel, measurement, forced_variance
//   result    result_valid/stall   result_channel, estimate
//   cfg       cfg_valid/ready      cfg_index, cfg_data
//
// A filter word runs from acceptance to result through the restoring divider
// that forms the gain and then two passes through one multiplier; with zero
// measurement noise or a zero gain denominator it skips the divider.
// A force word is applied when taken and gives no result. Reset is synchronous; it
// restores all channel estimates to 0 and variances to 1.0.
// The result sits in an output register, so a new word is taken while it waits;
// a finished filter word holds in its last state until that register frees up.
module scalar_kalman_filter_channels_core (
  input  logic                               clk,
  input  logic                               rst,
  // item channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               command,
  input  logic [skf_pkg::CH_W-1:0]           channel,
  input  logic signed [skf_pkg::MEAS_W-1:0]  measurement,
  input  logic [skf_pkg::VAR_W-1:0]          forced_variance,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [skf_pkg::CH_W-1:0]           result_channel,
  output logic signed [skf_pkg::EST_W-1:0]   estimate,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [skf_pkg::VAR_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOISE,
    S_GAIN,
    S_DIV,
    S_MULK,
    S_MULP,
    S_DONE
  } state_t;

  state_t                           state;

  // Registers and channel state
  logic [skf_pkg::VAR_W-1:0]        process_noise;
  logic [skf_pkg::VAR_W-1:0]        measurement_noise;
  logic signed [skf_pkg::EST_W-1:0] estimates [skf_pkg::CHANNELS];
  logic [skf_pkg::VAR_W-1:0]        variances [skf_pkg::CHANNELS];

  // Working registers of the current word
  logic [skf_pkg::CH_W-1:0]         ch;
  logic signed [skf_pkg::EST_W-1:0] meas8;
  logic [skf_pkg::VAR_W-1:0]        p;
  logic [skf_pkg::GAIN_W-1:0]       k;
  logic signed [skf_pkg::PROD_W-1:0] prod;

  logic                             item_take;
  logic                             out_free;
  logic [skf_pkg::VAR_W:0]          p_sum;
  logic [skf_pkg::DEN_W-1:0]        denom;
  logic signed [skf_pkg::DIFF_W-1:0] diff;
  logic signed [17:0]               mul_a;
  logic signed [25:0]               mul_b;
  logic signed [skf_pkg::PROD_W-1:0] mul_y;
  logic signed [skf_pkg::SUM_W-1:0] x_new;
  logic signed [skf_pkg::EST_W-1:0] x_clamped;
  logic [16:0]                      one_minus_k;

  skf_pkg::div_req_t                div_req;
  skf_pkg::div_rsp_t                div_rsp;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign cfg_ready  = 1'b1;

  // Predicted variance (saturated when registered in S_NOISE) and gain denominator
  assign p_sum = {1'b0, variances[ch]} + {1'b0, process_noise};
  assign denom = {1'b0, p} + {1'b0, measurement_noise};

  // Innovation in Q17.8
  assign diff = skf_pkg::DIFF_W'(meas8) - skf_pkg::DIFF_W'(estimates[ch]);

  // Shared multiplier: gain times innovation, then (1 - gain) times variance
  assign one_minus_k = 17'd65536 - {1'b0, k};
  always_comb begin
    if (state == S_MULK) begin
      mul_a = {2'b00, k};
      mul_b = 26'(diff);
    end else begin
      mul_a = {1'b0, one_minus_k};
      mul_b = {2'b00, p};
    end
  end
  assign mul_y = mul_a * mul_b;

  // Move the estimate by the floored correction and clamp
  assign x_new = skf_pkg::SUM_W'(estimates[ch]) + prod[skf_pkg::PROD_W-1:16];
  always_comb begin
    if (x_new < -(skf_pkg::SUM_W'(1) <<< (skf_pkg::EST_W - 1))) begin
      x_clamped = {1'b1, {(skf_pkg::EST_W-1){1'b0}}};
    end else if (x_new > $signed(skf_pkg::SUM_W'({1'b0, {(skf_pkg::EST_W-1){1'b1}}}))) begin
      x_clamped = {1'b0, {(skf_pkg::EST_W-1){1'b1}}};
    end else begin
      x_clamped = x_new[skf_pkg::EST_W-1:0];
    end
  end

  // Gain division request
  always_comb begin
    div_req.start = (state == S_GAIN) && (denom != '0) && (measurement_noise != '0);
    div_req.num   = p;
    div_req.den   = denom;
  end

  skf_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer, channel state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_valid      <= 1'b0;
      process_noise     <= skf_pkg::PROCESS_NOISE_RST;
      measurement_noise <= skf_pkg::MEASUREMENT_NOISE_RST;
      for (int i = 0; i < skf_pkg::CHANNELS; i++) begin
        estimates[i] <= '0;
        variances[i] <= skf_pkg::VARIANCE_RST;
      end
    end else begin
      // Drop the result once taken, unless a new one is loaded now
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE:     process_noise     <= cfg_data;
          skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item_take && (32'(channel) < skf_pkg::CHANNELS)) begin
            ch    <= channel;
            meas8 <= {measurement, 8'h00};
            if (command == skf_pkg::CMD_FORCE) begin
              estimates[channel] <= {measurement, 8'h00};
              variances[channel] <= forced_variance;
            end else begin
              state <= S_NOISE;
            end
          end
        end
        S_NOISE: begin
          p     <= p_sum[skf_pkg::VAR_W] ? skf_pkg::VAR_MAX : p_sum[skf_pkg::VAR_W-1:0];
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (denom == '0) begin
            k     <= '0;
            state <= S_MULK;
          end else if (measurement_noise == '0) begin
            k     <= skf_pkg::GAIN_MAX;
            state <= S_MULK;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            k     <= div_rsp.quot;
            state <= S_MULK;
          end
        end
        S_MULK: begin
          prod  <= mul_y;
          state <= S_MULP;
        end
        S_MULP: begin
          estimates[ch] <= x_clamped;
          prod          <= mul_y;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            variances[ch]  <= prod[skf_pkg::VAR_W+15:16];
            result_valid   <= 1'b1;
            result_channel <= ch;
            estimate       <= estimates[ch];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
